// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file rese_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define AST_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define AST_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// consequence checked in the clock cycle after the trigger
`define AST_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/rese_pkg.sv =====
// shared types and constants of the relative error statistics block
`timescale 1ns / 1ps
`default_nettype none

package rese_pkg;

	localparam int unsigned MAX_CELLS_DEF = 65536;
	localparam int unsigned FRAC_BITS_DEF = 16;

	localparam int unsigned VAL_W   = 32;
	localparam int unsigned POS_W   = 16;
	localparam int unsigned SUM_W   = 48;
	localparam int unsigned CNT_W   = 17;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic             done;
		logic             sat;
		logic [VAL_W-1:0] quot;
	} div_res_t;

endpackage

`default_nettype wire

// ===== rtl/rese_div.sv =====
// bit-serial restoring divider for the fixed-point relative error
`timescale 1ns / 1ps
`default_nettype none

module rese_div #(
	parameter int unsigned FRAC_BITS = rese_pkg::FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rese_pkg::VAL_W:0]    num,
	input  wire logic [rese_pkg::VAL_W-1:0]  den,
	output rese_pkg::div_res_t               res
);

	localparam int unsigned ShW   = rese_pkg::VAL_W - FRAC_BITS;
	localparam int unsigned WideW = rese_pkg::VAL_W + 1 + ShW;

	logic                          busy_q;
	logic [4:0]                    cnt_q;
	logic                          done_q;
	logic                          sat_q;
	logic [rese_pkg::VAL_W-1:0]    rem_q;
	logic [rese_pkg::VAL_W-1:0]    dsh_q;
	logic [rese_pkg::VAL_W-1:0]    den_q;
	logic [rese_pkg::VAL_W-1:0]    quot_q;

	logic [WideW-1:0]              num_wide;
	logic [WideW-1:0]              den_wide;
	logic [rese_pkg::VAL_W:0]      trial;
	logic [rese_pkg::VAL_W+1:0]    diff;

	// quotient reaches 2^32 exactly when num >= den << (32 - frac)
	assign num_wide = WideW'(num);
	assign den_wide = WideW'(den) << ShW;
	assign trial    = {rem_q, dsh_q[rese_pkg::VAL_W-1]};
	assign diff     = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// high part of num << frac is the starting remainder
			rem_q  <= rese_pkg::VAL_W'(num >> ShW);
			dsh_q  <= rese_pkg::VAL_W'(num << FRAC_BITS);
			den_q  <= den;
			sat_q  <= num_wide >= den_wide;
			quot_q <= '0;
		end else if (busy_q) begin
			dsh_q <= {dsh_q[rese_pkg::VAL_W-2:0], 1'b0};
			if (!diff[rese_pkg::VAL_W+1]) begin
				rem_q  <= diff[rese_pkg::VAL_W-1:0];
				quot_q <= {quot_q[rese_pkg::VAL_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial[rese_pkg::VAL_W-1:0];
				quot_q <= {quot_q[rese_pkg::VAL_W-2:0], 1'b0};
			end
		end
	end

	assign res.done = done_q;
	assign res.sat  = sat_q;
	assign res.quot = quot_q;

endmodule

`default_nettype wire

// ===== rtl/relative_error_statistics.sv =====
// top level: relative error per cell and running field statistics
`timescale 1ns / 1ps
`default_nettype none

// Takes one cell (computed and reference value, signed fixed point) per input
// transfer and returns one result transfer with the cell's relative error
// |a-b|/|b| (unsigned, same fraction bits, truncated, saturating at all ones)
// and the running minimum, maximum with its position, saturating sum and used
// count. A cell with either value zero is skipped but still advances the cell
// position. After the transfer marked tlast all statistics return to reset.
// An evaluated cell occupies the block from acceptance to the next acceptance,
// passing through the setup state, the bit-serial divider (one quotient bit
// per cycle), the divider's done report, the update state and the idle state
// that accepts the next cell; a skipped cell passes through setup, update
// and idle only. No new cell is accepted before the last one is through.
// The update state waits while the output register still holds an untaken
// result. The mean is left to software: error_total / used_total.
module relative_error_statistics #(
	parameter int unsigned MAX_CELLS = rese_pkg::MAX_CELLS_DEF,
	parameter int unsigned FRAC_BITS = rese_pkg::FRAC_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [63:0]  s_tdata,  // first_value, second_value
	input  wire logic         s_tlast,  // last_cell
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// cell_error, minimum_error, maximum_error, maximum_position, error_total,
	// used_total, zero pad
	output logic [183:0]      m_tdata,
	output logic [1:0]        m_tuser,  // cell_used, maximum_seen
	output logic              m_tlast   // final_result
);

	localparam int unsigned VW = rese_pkg::VAL_W;
	localparam int unsigned PW = rese_pkg::POS_W;
	localparam int unsigned SW = rese_pkg::SUM_W;
	localparam int unsigned CW = rese_pkg::CNT_W;

	localparam longint unsigned MinRaw = 64'd9999 << FRAC_BITS;
	localparam logic [VW-1:0] MinReset =
		(MinRaw > 64'hFFFF_FFFF) ? {VW{1'b1}} : VW'(MinRaw);
	localparam logic [24:0] MaxCellsW = 25'(MAX_CELLS);

	rese_pkg::state_t state_q, state_nx;

	logic [VW-1:0]  a_q, b_q;
	logic           last_q;
	logic           used_q;

	logic [PW-1:0]  pos_q;
	logic [VW-1:0]  min_q, max_q;
	logic [PW-1:0]  peak_q;
	logic           seen_q;
	logic [SW-1:0]  sum_q;
	logic [CW-1:0]  cnt_q;

	logic           ovalid_q;
	logic [VW-1:0]  o_err_q, o_min_q, o_max_q;
	logic [PW-1:0]  o_peak_q;
	logic           o_used_q, o_seen_q, o_last_q;
	logic [SW-1:0]  o_sum_q;
	logic [CW-1:0]  o_cnt_q;

	logic           used_now;
	logic [VW:0]    diff;
	logic [VW:0]    num;
	logic [VW-1:0]  den;
	logic           div_start;
	rese_pkg::div_res_t div_res;

	logic           slot_free;
	logic           commit;
	logic [VW-1:0]  err;
	logic [VW-1:0]  min_nx, max_nx;
	logic [PW-1:0]  peak_nx;
	logic           seen_nx;
	logic [SW:0]    sum_add;
	logic [SW-1:0]  sum_nx;
	logic [CW-1:0]  cnt_nx;
	logic [24:0]    pos_inc;

	assign used_now  = (a_q != '0) && (b_q != '0);
	assign diff      = {a_q[VW-1], a_q} - {b_q[VW-1], b_q};
	assign num       = diff[VW] ? (~diff + 1'b1) : diff;
	assign den       = b_q[VW-1] ? (~b_q + 1'b1) : b_q;
	assign div_start = (state_q == rese_pkg::ST_PREP) && used_now;

	rese_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rese_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign slot_free = !ovalid_q || m_tready;

	always_comb begin
		state_nx = state_q;
		s_tready = 1'b0;
		commit   = 1'b0;
		case (state_q)
			rese_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_nx = rese_pkg::ST_PREP;
			end
			rese_pkg::ST_PREP: begin
				state_nx = used_now ? rese_pkg::ST_DIV : rese_pkg::ST_DONE;
			end
			rese_pkg::ST_DIV: begin
				if (div_res.done) state_nx = rese_pkg::ST_DONE;
			end
			rese_pkg::ST_DONE: begin
				if (slot_free) begin
					commit   = 1'b1;
					state_nx = rese_pkg::ST_IDLE;
				end
			end
			default: state_nx = rese_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			a_q    <= s_tdata[VW-1:0];
			b_q    <= s_tdata[2*VW-1:VW];
			last_q <= s_tlast;
		end
		if (state_q == rese_pkg::ST_PREP) begin
			used_q <= used_now;
		end
	end

	// statistics after this cell
	always_comb begin
		if (!used_q) begin
			err = '0;
		end else if (div_res.sat) begin
			err = {VW{1'b1}};
		end else begin
			err = div_res.quot;
		end
		min_nx  = min_q;
		max_nx  = max_q;
		peak_nx = peak_q;
		seen_nx = seen_q;
		sum_nx  = sum_q;
		cnt_nx  = cnt_q;
		sum_add = {1'b0, sum_q} + (SW + 1)'(err);
		if (used_q) begin
			if (err < min_q) min_nx = err;
			if (err > max_q) begin
				max_nx  = err;
				peak_nx = pos_q;
				seen_nx = 1'b1;
			end
			sum_nx = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
			if (cnt_q != {CW{1'b1}}) cnt_nx = cnt_q + 1'b1;
		end
		pos_inc = 25'(pos_q) + 25'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			min_q  <= MinReset;
			max_q  <= '0;
			peak_q <= '0;
			seen_q <= 1'b0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else if (commit) begin
			if (last_q) begin
				pos_q  <= '0;
				min_q  <= MinReset;
				max_q  <= '0;
				peak_q <= '0;
				seen_q <= 1'b0;
				sum_q  <= '0;
				cnt_q  <= '0;
			end else begin
				pos_q  <= (pos_inc >= MaxCellsW) ? '0 : pos_inc[PW-1:0];
				min_q  <= min_nx;
				max_q  <= max_nx;
				peak_q <= peak_nx;
				seen_q <= seen_nx;
				sum_q  <= sum_nx;
				cnt_q  <= cnt_nx;
			end
		end
	end

	// output register, freed by the downstream transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (commit) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			o_err_q  <= err;
			o_used_q <= used_q;
			o_last_q <= last_q;
			o_min_q  <= min_nx;
			o_max_q  <= max_nx;
			o_peak_q <= peak_nx;
			o_seen_q <= seen_nx;
			o_sum_q  <= sum_nx;
			o_cnt_q  <= cnt_nx;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tlast  = o_last_q;
	assign m_tuser  = {o_seen_q, o_used_q};
	assign m_tdata  = {7'd0, o_cnt_q, o_sum_q, o_peak_q, o_max_q, o_min_q, o_err_q};

endmodule

`default_nettype wire

// ===== rtl/rese_chk.sv =====
// port-level checker for the relative error statistics block
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rese_chk (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [183:0] m_tdata,
	input  wire logic [1:0]   m_tuser
);

	// one cell in flight at a time
	`AST_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")

	`AST_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

	// skipped cell reports zero error
	`AST_IMPLY(a_skip_zero, m_tvalid && !m_tuser[0], m_tdata[31:0] == 32'd0, "skip error")

	`AST_IMPLY(a_used_count, m_tvalid && m_tuser[0], m_tdata[176:160] != 17'd0, "count zero")

	// no peak recorded means maximum and position still at reset
	`AST_ALWAYS(a_peak_reset,
		!(m_tvalid && !m_tuser[1]) || (m_tdata[95:64] == 32'd0 && m_tdata[111:96] == 16'd0),
		"peak without seen flag")

endmodule

bind relative_error_statistics rese_chk u_rese_chk (.*);

`default_nettype wire
